// ===== rtl/sync_header_frame_deframer_assert.svh =====
// Assertion macros shared by the checker of the sync header frame deframer.
// Depends on nothing; included by the files that hold concurrent assertions.
`ifndef SYNC_HEADER_FRAME_DEFRAMER_ASSERT_SVH
`define SYNC_HEADER_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled while the reset is asserted.
`define SHFD_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("shfd assertion failed");

// Next-cycle implication, disabled while the reset is asserted.
`define SHFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("shfd assertion failed");

`endif

// ===== rtl/shfd_pkg.sv =====
// Package of the sync header frame deframer: frame constants and result type.
// Depends on nothing; used by the parser, output stage, top and testbench.
package shfd_pkg;

  localparam int unsigned PosWidth = 4;

  localparam logic [7:0] SyncFirst  = 8'hAB;
  localparam logic [7:0] SyncSecond = 8'hCD;

  // Frame byte positions.
  localparam logic [PosWidth-1:0] PosHunt    = 4'd0;
  localparam logic [PosWidth-1:0] PosSync2   = 4'd1;
  localparam logic [PosWidth-1:0] PosTag     = 4'd2;
  localparam logic [PosWidth-1:0] PosDistHi  = 4'd3;
  localparam logic [PosWidth-1:0] PosDistLo  = 4'd4;
  localparam logic [PosWidth-1:0] PosXHi     = 4'd5;
  localparam logic [PosWidth-1:0] PosXLo     = 4'd6;
  localparam logic [PosWidth-1:0] PosZHi     = 4'd7;
  localparam logic [PosWidth-1:0] PosZLo     = 4'd8;
  localparam logic [PosWidth-1:0] PosPitchHi = 4'd9;
  localparam logic [PosWidth-1:0] PosPitchLo = 4'd10;
  localparam logic [PosWidth-1:0] PosCheck   = 4'd12;
  localparam logic [PosWidth-1:0] PosLast    = 4'd13;

  typedef struct packed {
    logic [7:0]         tag_id;
    logic [15:0]        distance_tenths;
    logic signed [15:0] x_tenths;
    logic signed [15:0] z_tenths;
    logic signed [15:0] pitch_tenths;
    logic               checksum_ok;
  } result_t;

endpackage

// ===== rtl/shfd_if.sv =====
// Stream interfaces of the sync header frame deframer: received bytes in,
// decoded frames out. Depends on nothing.
interface shfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface shfd_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         tag_id;
  logic [15:0]        distance_tenths;
  logic signed [15:0] x_tenths;
  logic signed [15:0] z_tenths;
  logic signed [15:0] pitch_tenths;
  logic               checksum_ok;

  modport source (
    output valid, output tag_id, output distance_tenths, output x_tenths,
    output z_tenths, output pitch_tenths, output checksum_ok, input ready
  );
  modport sink (
    input valid, input tag_id, input distance_tenths, input x_tenths,
    input z_tenths, input pitch_tenths, input checksum_ok, output ready
  );
endinterface

// ===== rtl/shfd_in_stage.sv =====
// Input register of the deframer: holds one received word until it is parsed.
// Depends on nothing but the clock and reset.
module shfd_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] byte_i,
  output logic       ready_o,
  input  logic       advance_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q;
  logic [7:0] byte_q;

  // The register may load when empty or when its word moves on this cycle.
  assign ready_o = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      byte_q <= byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// ===== rtl/shfd_parser.sv =====
// Frame parser: position counter, running XOR and field capture registers.
// Depends on shfd_pkg for the frame constants and the result type.
module shfd_parser
  import shfd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] byte_i,
  input  logic       advance_i,
  output logic       emit_o,
  output result_t    result_o
);

  logic [PosWidth-1:0] pos_q, pos_d, pos_eff;
  logic [7:0]          xor_q, xor_d;
  logic [7:0]          tag_q, tag_d;
  logic [15:0]         dist_q, dist_d;
  logic [15:0]         x_q, x_d;
  logic [15:0]         z_q, z_d;
  logic [15:0]         pitch_q, pitch_d;
  logic [7:0]          check_q, check_d;

  // Positions past the last byte cannot occur; they are handled as hunting.
  assign pos_eff = (pos_q > PosLast) ? PosHunt : pos_q;
  assign emit_o  = valid_i && (pos_eff == PosLast);

  always_comb begin
    pos_d   = pos_q;
    xor_d   = xor_q;
    tag_d   = tag_q;
    dist_d  = dist_q;
    x_d     = x_q;
    z_d     = z_q;
    pitch_d = pitch_q;
    check_d = check_q;
    if (advance_i) begin
      if (pos_eff == PosHunt) begin
        if (byte_i == SyncFirst) begin
          xor_d = byte_i;
          pos_d = PosSync2;
        end else begin
          pos_d = PosHunt;
        end
      end else if ((pos_eff == PosSync2) && (byte_i != SyncSecond)) begin
        // A wrong second sync word is dropped, not taken as a new first one.
        pos_d = PosHunt;
      end else begin
        if (pos_eff < PosCheck) begin
          xor_d = xor_q ^ byte_i;
        end
        case (pos_eff)
          PosTag:     tag_d   = byte_i;
          PosDistHi:  dist_d  = {byte_i, 8'h00};
          PosDistLo:  dist_d  = {dist_q[15:8], byte_i};
          PosXHi:     x_d     = {byte_i, 8'h00};
          PosXLo:     x_d     = {x_q[15:8], byte_i};
          PosZHi:     z_d     = {byte_i, 8'h00};
          PosZLo:     z_d     = {z_q[15:8], byte_i};
          PosPitchHi: pitch_d = {byte_i, 8'h00};
          PosPitchLo: pitch_d = {pitch_q[15:8], byte_i};
          PosCheck:   check_d = byte_i;
          default:    ;
        endcase
        pos_d = (pos_eff == PosLast) ? PosHunt : pos_eff + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= PosHunt;
      xor_q   <= '0;
      tag_q   <= '0;
      dist_q  <= '0;
      x_q     <= '0;
      z_q     <= '0;
      pitch_q <= '0;
      check_q <= '0;
    end else begin
      pos_q   <= pos_d;
      xor_q   <= xor_d;
      tag_q   <= tag_d;
      dist_q  <= dist_d;
      x_q     <= x_d;
      z_q     <= z_d;
      pitch_q <= pitch_d;
      check_q <= check_d;
    end
  end

  assign result_o.tag_id          = tag_q;
  assign result_o.distance_tenths = dist_q;
  assign result_o.x_tenths        = signed'(x_q);
  assign result_o.z_tenths        = signed'(z_q);
  assign result_o.pitch_tenths    = signed'(pitch_q);
  assign result_o.checksum_ok     = (check_q == xor_q);

endmodule

// ===== rtl/shfd_out_stage.sv =====
// Output register of the deframer: holds one decoded frame until it is taken.
// Depends on shfd_pkg for the result type.
module shfd_out_stage
  import shfd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  output logic    free_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t result_o
);

  logic    valid_q;
  result_t result_q;

  assign free_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ===== rtl/sync_header_frame_deframer.sv =====
// Top level of the sync header frame deframer.
// Depends on shfd_pkg, shfd_if, shfd_in_stage, shfd_parser and shfd_out_stage.
//
// The block takes one received serial word per handshake on rx_i and hunts
// for a 14-word frame that opens with the sync words 0xAB, 0xCD. When the
// last word of a frame is taken it offers one decoded frame on frame_o: the
// tag, the big-endian distance, x, z and pitch fields in tenths, and a flag
// that says whether word 12 matched the XOR of words 0 to 11.
// Both channels are valid/ready; a word moves on an edge where both are high.
// The closing word is held in the input register, its frame in the output one.
// Throughput: one word per cycle, except when a closing word meets a full
// output register; that register lets other words flow on while a frame waits.
// Reset clears the position counter, the running XOR and the captured fields,
// and empties both registers, so the block starts hunting for a first sync.
// When the receiver stalls, the frame is held in the output register; words
// that close no frame still pass, and rx_i.ready falls only when the word
// in the input register would produce a second frame.
module sync_header_frame_deframer
  import shfd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  shfd_in_if.sink           rx_i,
  shfd_out_if.source        frame_o
);

  logic    s1_valid;
  logic [7:0] s1_byte;
  logic    emit;
  logic    out_free;
  logic    advance;
  result_t parsed;
  result_t held;

  // The input word is consumed when it either closes no frame, or the output
  // register can take the frame it closes.
  assign advance = s1_valid && (!emit || out_free);

  shfd_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (rx_i.valid),
    .byte_i    (rx_i.rx_byte),
    .ready_o   (rx_i.ready),
    .advance_i (advance),
    .valid_o   (s1_valid),
    .byte_o    (s1_byte)
  );

  shfd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s1_valid),
    .byte_i    (s1_byte),
    .advance_i (advance),
    .emit_o    (emit),
    .result_o  (parsed)
  );

  shfd_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance && emit),
    .result_i (parsed),
    .free_o   (out_free),
    .valid_o  (frame_o.valid),
    .ready_i  (frame_o.ready),
    .result_o (held)
  );

  assign frame_o.tag_id          = held.tag_id;
  assign frame_o.distance_tenths = held.distance_tenths;
  assign frame_o.x_tenths        = held.x_tenths;
  assign frame_o.z_tenths        = held.z_tenths;
  assign frame_o.pitch_tenths    = held.pitch_tenths;
  assign frame_o.checksum_ok     = held.checksum_ok;

endmodule

// ===== rtl/shfd_checker.sv =====
// Port-level checker of the sync header frame deframer and its bind.
// Depends on sync_header_frame_deframer_assert.svh and the top level.
`include "sync_header_frame_deframer_assert.svh"

module shfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [72:0] out_payload_i
);

  // A held frame stays offered until it is taken.
  `SHFD_ASSERT_NEXT(a_out_valid_holds, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  // A stalled frame keeps its fields.
  `SHFD_ASSERT_NEXT(a_out_payload_holds, clk_i, rst_ni,
                    out_valid_i && !out_ready_i, $stable(out_payload_i))

  // With nothing held at the output, a word is always taken.
  `SHFD_ASSERT_IMPLIES(a_ready_when_empty, clk_i, rst_ni, !out_valid_i, in_ready_i)

  // A new frame appears only once the word that closes it has passed the input
  // register, and the frame it closes has been loaded into the output register.
  `SHFD_ASSERT_IMPLIES(a_frame_follows_word, clk_i, rst_ni,
                       $rose(out_valid_i), $past(in_valid_i && in_ready_i, 2))

endmodule

bind sync_header_frame_deframer shfd_checker u_shfd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (rx_i.valid),
  .in_ready_i    (rx_i.ready),
  .out_valid_i   (frame_o.valid),
  .out_ready_i   (frame_o.ready),
  .out_payload_i ({frame_o.tag_id, frame_o.distance_tenths, frame_o.x_tenths,
                   frame_o.z_tenths, frame_o.pitch_tenths, frame_o.checksum_ok})
);

// ===== test/sync_header_frame_deframer_tb.sv =====
`timescale 1ns / 1ps
// Testbench of the sync header frame deframer: drives received words, predicts the decoded frames.
// Depends on shfd_pkg, shfd_if and sync_header_frame_deframer.
module sync_header_frame_deframer_tb;
  import shfd_pkg::*;

  // Frame length in words, and the timing limits of the run.
  localparam int unsigned FrameWords    = 14;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned DrainCycles   = 8;

  // A frame typed in by hand. When set, it replaces the predicted frame for the
  // word that closes it, so that the simple cases do not lean on the predictor.
  typedef struct packed {
    logic    on;
    result_t frame;
  } typed_frame_t;

  // One row of the directed table: either a single stray word or a whole frame.
  typedef struct {
    bit           lone;
    logic [7:0]   word;
    logic [7:0]   tag;
    logic [15:0]  distance;
    logic [15:0]  x;
    logic [15:0]  z;
    logic [15:0]  pitch;
    logic [7:0]   spare;
    logic [7:0]   flip;
    logic [7:0]   last;
    typed_frame_t fixed;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  shfd_in_if  rx_bus ();
  shfd_out_if frame_bus ();

  sync_header_frame_deframer uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (rx_bus),
    .frame_o (frame_bus)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor state: the position of the next frame word, the running XOR and
  // the fields captured so far. All of it starts at zero, as after reset.
  logic [PosWidth-1:0] dec_pos   = PosHunt;
  logic [7:0]          dec_xor   = 8'h00;
  logic [7:0]          dec_tag   = 8'h00;
  logic [15:0]         dec_dist  = 16'h0000;
  logic [15:0]         dec_x     = 16'h0000;
  logic [15:0]         dec_z     = 16'h0000;
  logic [15:0]         dec_pitch = 16'h0000;
  logic [7:0]          dec_check = 8'h00;

  result_t      pending_frames [$];   // frames still owed by the block, oldest first
  typed_frame_t offered_words [$];    // one entry per word put on the bus, in order
  int unsigned  errors = 0;
  int unsigned  idle_cycles = 0;

  // Run shaping, shared by the sender and the receiver.
  bit calm     = 1'b0;   // no random gaps on either side while set
  bit hold_req = 1'b0;   // asks the receiver for one long hold-off

  const typed_frame_t unchecked = '0;

  // Advances the predictor by one received word. Returns 1 and the decoded
  // frame when the word closes a frame.
  function automatic bit deframe_word(input logic [7:0] b, output result_t frame);
    logic [PosWidth-1:0] pos;
    pos   = dec_pos;
    frame = '0;
    // The two unused position codes behave as hunting.
    if (pos > PosLast) pos = PosHunt;
    if (pos == PosHunt) begin
      if (b == SyncFirst) begin
        dec_xor = b;
        dec_pos = PosSync2;
      end else begin
        dec_pos = PosHunt;
      end
      return 1'b0;
    end
    // A wrong second sync word is dropped; it is never taken as a new first sync.
    if (pos == PosSync2 && b != SyncSecond) begin
      dec_pos = PosHunt;
      return 1'b0;
    end
    if (pos < PosCheck) dec_xor = dec_xor ^ b;
    case (pos)
      PosTag:     dec_tag = b;
      PosDistHi:  dec_dist = {b, 8'h00};
      PosDistLo:  dec_dist[7:0] = b;
      PosXHi:     dec_x = {b, 8'h00};
      PosXLo:     dec_x[7:0] = b;
      PosZHi:     dec_z = {b, 8'h00};
      PosZLo:     dec_z[7:0] = b;
      PosPitchHi: dec_pitch = {b, 8'h00};
      PosPitchLo: dec_pitch[7:0] = b;
      PosCheck:   dec_check = b;
      default: ;
    endcase
    if (pos < PosLast) begin
      dec_pos = pos + 1'b1;
      return 1'b0;
    end
    // The last word only closes the frame; its value plays no part.
    dec_pos               = PosHunt;
    frame.tag_id          = dec_tag;
    frame.distance_tenths = dec_dist;
    frame.x_tenths        = dec_x;
    frame.z_tenths        = dec_z;
    frame.pitch_tenths    = dec_pitch;
    frame.checksum_ok     = (dec_check == dec_xor);
    return 1'b1;
  endfunction

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm) return 0;
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Field values that favour the corners of the 16-bit range.
  function automatic logic [15:0] pick_field();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic stim_row_t stray_row(input logic [7:0] b);
    stim_row_t row;
    row      = '{default: '0};
    row.lone = 1'b1;
    row.word = b;
    return row;
  endfunction

  function automatic stim_row_t frame_row(
    input logic [7:0] tag, input logic [15:0] distance, input logic [15:0] x,
    input logic [15:0] z, input logic [15:0] pitch, input logic [7:0] spare,
    input logic [7:0] flip, input logic [7:0] last, input typed_frame_t fixed
  );
    stim_row_t row;
    row          = '{default: '0};
    row.tag      = tag;
    row.distance = distance;
    row.x        = x;
    row.z        = z;
    row.pitch    = pitch;
    row.spare    = spare;
    row.flip     = flip;
    row.last     = last;
    row.fixed    = fixed;
    return row;
  endfunction

  // Offers one word and returns at the edge where it is taken. Valid is only
  // lowered when a gap follows, so back-to-back words keep it high throughout.
  task automatic send_word(input logic [7:0] b, input typed_frame_t fixed);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      rx_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_bus.valid   <= 1'b1;
    rx_bus.rx_byte <= b;
    offered_words.push_back(fixed);
    do @(posedge clk_i); while (!rx_bus.ready);
  endtask

  // Builds a frame with a check word that is right when flip is zero, and
  // sends its first count words. A short count leaves the frame unfinished.
  task automatic send_frame(
    input logic [7:0] tag, input logic [15:0] distance, input logic [15:0] x,
    input logic [15:0] z, input logic [15:0] pitch, input logic [7:0] spare,
    input logic [7:0] flip, input logic [7:0] last, input int unsigned count,
    input typed_frame_t fixed
  );
    logic [7:0] w [FrameWords];
    logic [7:0] sum;
    w[0]  = SyncFirst;
    w[1]  = SyncSecond;
    w[2]  = tag;
    w[3]  = distance[15:8];
    w[4]  = distance[7:0];
    w[5]  = x[15:8];
    w[6]  = x[7:0];
    w[7]  = z[15:8];
    w[8]  = z[7:0];
    w[9]  = pitch[15:8];
    w[10] = pitch[7:0];
    w[11] = spare;
    w[13] = last;
    sum   = 8'h00;
    for (int i = 0; i < 12; i++) sum = sum ^ w[i];
    w[12] = sum ^ flip;
    for (int i = 0; i < count; i++)
      send_word(w[i], (i == FrameWords - 1) ? fixed : unchecked);
  endtask

  // Lowers valid and waits until every frame owed has been taken. The first
  // edge lets the monitor log a frame closed by the word just accepted.
  task automatic wait_for_frames();
    rx_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_frames.size() != 0) @(posedge clk_i);
  endtask

  task automatic compare_frame(input result_t want, input result_t got);
    if (want.tag_id !== got.tag_id) begin
      $display("%0t: tag_id expected %h, got %h", $time, want.tag_id, got.tag_id);
      errors++;
    end
    if (want.distance_tenths !== got.distance_tenths) begin
      $display("%0t: distance_tenths expected %h, got %h", $time,
               want.distance_tenths, got.distance_tenths);
      errors++;
    end
    if (want.x_tenths !== got.x_tenths) begin
      $display("%0t: x_tenths expected %0d, got %0d", $time, want.x_tenths, got.x_tenths);
      errors++;
    end
    if (want.z_tenths !== got.z_tenths) begin
      $display("%0t: z_tenths expected %0d, got %0d", $time, want.z_tenths, got.z_tenths);
      errors++;
    end
    if (want.pitch_tenths !== got.pitch_tenths) begin
      $display("%0t: pitch_tenths expected %0d, got %0d", $time,
               want.pitch_tenths, got.pitch_tenths);
      errors++;
    end
    if (want.checksum_ok !== got.checksum_ok) begin
      $display("%0t: checksum_ok expected %b, got %b", $time,
               want.checksum_ok, got.checksum_ok);
      errors++;
    end
  endtask

  // Monitor. Both channels are sampled at the rising edge, before anything
  // driven at that edge takes effect. The input side is handled first, so
  // that a frame is owed before the output side can be asked for it.
  always @(posedge clk_i) begin : monitor_b
    typed_frame_t fixed;
    result_t      predicted;
    result_t      got;
    bit           closes;
    if (rst_ni) begin
      if (rx_bus.valid && rx_bus.ready) begin
        fixed  = offered_words.pop_front();
        closes = deframe_word(rx_bus.rx_byte, predicted);
        if (fixed.on) pending_frames.push_back(fixed.frame);
        else if (closes) pending_frames.push_back(predicted);
      end
      if (frame_bus.valid && frame_bus.ready) begin
        got.tag_id          = frame_bus.tag_id;
        got.distance_tenths = frame_bus.distance_tenths;
        got.x_tenths        = frame_bus.x_tenths;
        got.z_tenths        = frame_bus.z_tenths;
        got.pitch_tenths    = frame_bus.pitch_tenths;
        got.checksum_ok     = frame_bus.checksum_ok;
        if (pending_frames.size() == 0) begin
          $display("%0t: unexpected frame, tag_id %h", $time, got.tag_id);
          errors++;
        end else begin
          compare_frame(pending_frames.pop_front(), got);
        end
      end
    end
  end

  // Watchdog: the run is stuck once neither channel has moved a word for
  // far longer than the longest stall that the stimulus can cause.
  always @(posedge clk_i) begin
    if (!rst_ni || (rx_bus.valid && rx_bus.ready) || (frame_bus.valid && frame_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver. Ready comes in windows broken by gaps of random length. Once
  // asked, it holds ready low for a long, fixed stretch, so that a frame sits
  // in the output register and the block has to stall its input.
  initial begin : receiver_b
    int unsigned gap;
    frame_bus.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        frame_bus.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end
      frame_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      gap = pick_gap();
      if (gap != 0) begin
        frame_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  // Sender and run control.
  initial begin : sender_b
    stim_row_t   stim_rows [$];
    int unsigned frame_words;
    int unsigned frames_done;
    int unsigned roll;
    int unsigned cut;
    bit          hold_done;
    bit          pause_done;
    logic [7:0]  flip;
    logic [7:0]  b;

    rx_bus.valid   <= 1'b0;
    rx_bus.rx_byte <= 8'h00;
    frame_words = 0;
    frames_done = 0;
    hold_done   = 1'b0;
    pause_done  = 1'b0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Stray words while hunting are dropped, a second sync
    // word included.
    stim_rows.push_back(stray_row(8'h00));
    stim_rows.push_back(stray_row(8'hFF));
    stim_rows.push_back(stray_row(SyncSecond));
    // A wrong second sync word drops the hunt, and a repeated first sync word
    // is not taken as the start of a new frame: the second sync after it is
    // stray again.
    stim_rows.push_back(stray_row(SyncFirst));
    stim_rows.push_back(stray_row(8'h12));
    stim_rows.push_back(stray_row(SyncFirst));
    stim_rows.push_back(stray_row(SyncFirst));
    stim_rows.push_back(stray_row(SyncSecond));
    // All fields zero and all fields ones, both with a good check word.
    stim_rows.push_back(frame_row(8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                  8'h00, 8'h00, 8'h00,
                                  '{1'b1, result_t'{8'h00, 16'h0000, 16'sh0000,
                                                    16'sh0000, 16'sh0000, 1'b1}}));
    stim_rows.push_back(frame_row(8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                  8'hFF, 8'h00, 8'hFF,
                                  '{1'b1, result_t'{8'hFF, 16'hFFFF, -16'sd1,
                                                    -16'sd1, -16'sd1, 1'b1}}));
    // Signed extremes with a bad check word: the frame still comes out.
    stim_rows.push_back(frame_row(8'h80, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                  8'h00, 8'hFF, 8'h00,
                                  '{1'b1, result_t'{8'h80, 16'h8000, 16'sh8000,
                                                    16'sh8000, 16'sh8000, 1'b0}}));
    stim_rows.push_back(frame_row(8'h7F, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                  8'h55, 8'h01, 8'h7F,
                                  '{1'b1, result_t'{8'h7F, 16'h7FFF, 16'sh7FFF,
                                                    16'sh7FFF, 16'sh7FFF, 1'b0}}));
    // Sync values inside the payload, and a last word equal to the first
    // sync: it only closes the frame, so the second sync after it is stray.
    stim_rows.push_back(frame_row(SyncFirst, 16'hCDAB, 16'h1234, 16'h00CD, 16'hABCD,
                                  8'h5A, 8'h00, SyncFirst, unchecked));
    stim_rows.push_back(stray_row(SyncSecond));
    stim_rows.push_back(frame_row(8'h3C, 16'h0102, 16'hFF80, 16'h0080, 16'hC000,
                                  8'hA5, 8'h80, 8'h96, unchecked));

    foreach (stim_rows[i]) begin
      if (stim_rows[i].lone) begin
        send_word(stim_rows[i].word, unchecked);
      end else begin
        send_frame(stim_rows[i].tag, stim_rows[i].distance, stim_rows[i].x,
                   stim_rows[i].z, stim_rows[i].pitch, stim_rows[i].spare,
                   stim_rows[i].flip, stim_rows[i].last, FrameWords, stim_rows[i].fixed);
      end
    end

    // Random part: mostly whole frames with random content, about a third of
    // them with a bad check word, mixed with stray words, broken sync pairs
    // and frames cut short.
    while (frame_words < 400 || frames_done < 26) begin
      // The long hold-off runs over a calm stretch, so that the block fills up.
      if (frames_done == 8 && !hold_done) begin
        hold_done = 1'b1;
        hold_req  = 1'b1;
      end
      // Once mid-run, the sender stops until the block has delivered all.
      if (frames_done == 16 && !pause_done) begin
        pause_done = 1'b1;
        wait_for_frames();
      end
      calm = (frames_done >= 8 && frames_done < 12) || (frames_done >= 20 && frames_done < 26);

      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        flip = 8'h00;
        if ($urandom_range(0, 2) == 0) flip = 8'($urandom_range(1, 255));
        send_frame(8'($urandom), pick_field(), pick_field(), pick_field(), pick_field(),
                   8'($urandom), flip, 8'($urandom), FrameWords, unchecked);
        frame_words += FrameWords;
        frames_done++;
      end else if (roll < 85) begin
        repeat ($urandom_range(1, 4)) send_word(8'($urandom), unchecked);
      end else if (roll < 95) begin
        b = 8'($urandom);
        if (b == SyncSecond) b = ~b;
        send_word(SyncFirst, unchecked);
        send_word(b, unchecked);
      end else begin
        // A frame cut short: the words that follow are taken as its rest.
        cut = $urandom_range(2, FrameWords - 1);
        send_frame(8'($urandom), pick_field(), pick_field(), pick_field(), pick_field(),
                   8'($urandom), 8'h00, 8'($urandom), cut, unchecked);
        frame_words += cut;
      end
    end
    calm = 1'b0;

    // Let the last frames out, then allow for the output stage before ending.
    wait_for_frames();
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/shfd_pkg.sv
rtl/shfd_if.sv
rtl/shfd_in_stage.sv
rtl/shfd_parser.sv
rtl/shfd_out_stage.sv
rtl/sync_header_frame_deframer.sv
rtl/shfd_checker.sv
test/sync_header_frame_deframer_tb.sv
